@@ rtl/tgf_pkg.sv @@
// Shared constants and codes for the team grouped FIFO.
package tgf_pkg;

	localparam int NODE_CAPACITY_DEF = 1024;
	localparam int TEAM_COUNT_DEF    = 1024;
	localparam int ID_BITS           = 20;
	localparam int ITEM_IN_W         = 20;
	localparam int TEAM_IN_W         = 10;
	localparam int ITEM_W            = (ID_BITS < ITEM_IN_W) ? ID_BITS : ITEM_IN_W;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] STAT_ENQ   = 2'd0;
	localparam logic [1:0] STAT_DEQ   = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

endpackage

@@ rtl/tgf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tgf_team_reduce.sv @@
// Team index reduction modulo the team count: reciprocal multiply, then one correction.
module tgf_team_reduce
	import tgf_pkg::*;
#(
	parameter int TEAM_COUNT = TEAM_COUNT_DEF,
	localparam int TW = (TEAM_COUNT > 1) ? $clog2(TEAM_COUNT) : 1
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic [TEAM_IN_W-1:0] team_in,
	output logic [TW-1:0]        team_idx
);

	localparam int RECIP_SH = 20;
	localparam logic [RECIP_SH:0] RECIP = (RECIP_SH + 1)'((1 << RECIP_SH) / TEAM_COUNT);

	logic [TEAM_IN_W+RECIP_SH:0] prod;
	logic [TEAM_IN_W-1:0]        quot_s1;
	logic [TEAM_IN_W-1:0]        team_s1;
	logic [31:0]                 back;
	logic [TEAM_IN_W-1:0]        rem;
	logic [16:0]                 rem_ext;
	logic [16:0]                 rem_fix;

	assign prod = (TEAM_IN_W + RECIP_SH + 1)'(team_in) * (TEAM_IN_W + RECIP_SH + 1)'(RECIP);

	always_ff @(posedge clk) begin
		if (load) begin
			quot_s1 <= prod[RECIP_SH +: TEAM_IN_W];
			team_s1 <= team_in;
		end
	end

	assign back    = 32'(quot_s1) * 32'(TEAM_COUNT);
	assign rem     = team_s1 - back[TEAM_IN_W-1:0];
	assign rem_ext = 17'(rem);
	assign rem_fix = (rem_ext >= 17'(TEAM_COUNT)) ? rem_ext - 17'(TEAM_COUNT) : rem_ext;
	assign team_idx = rem_fix[TW-1:0];

endmodule

@@ rtl/team_grouped_fifo.sv @@
// Team grouped FIFO: linked list of nodes, items queued behind the last member of their team.
// Full or empty requests answer in the cycle after accept. A dequeue steps through S_DEQ_A
// and S_DEQ_B; an enqueue that opens a new team group steps through S_MOD and S_ENQ_A; an
// enqueue behind a team member also passes S_ENQ_B and S_ENQ_C (extra link read and two
// link writes on the one link write port). busy is high until done; one request at a time,
// so the next one may start in the cycle done is high; done is a single-cycle strobe.
// After reset, busy is high while the team table is cleared.
module team_grouped_fifo
	import tgf_pkg::*;
#(
	parameter int NODE_CAPACITY = NODE_CAPACITY_DEF,
	parameter int TEAM_COUNT    = TEAM_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [ITEM_IN_W-1:0] item_id,
	input  logic [TEAM_IN_W-1:0] team,
	output logic                 done,
	output logic [1:0]           status,
	output logic [ITEM_IN_W-1:0] out_item
);

	localparam int NW = $clog2(NODE_CAPACITY);
	localparam int CW = $clog2(NODE_CAPACITY + 1);
	localparam int TW = (TEAM_COUNT > 1) ? $clog2(TEAM_COUNT) : 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_ENQ_A = 3'd3;
	localparam logic [2:0] S_ENQ_B = 3'd4;
	localparam logic [2:0] S_ENQ_C = 3'd5;
	localparam logic [2:0] S_DEQ_A = 3'd6;
	localparam logic [2:0] S_DEQ_B = 3'd7;

	logic [2:0]        state_q;
	logic [TW-1:0]     clr_q;
	logic [NW-1:0]     head_q;
	logic [NW-1:0]     tail_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     fresh_q;
	logic [CW-1:0]     fcnt_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [ITEM_IN_W-1:0] out_item_q;
	logic [ITEM_W-1:0] item_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     p_q;
	logic [TW-1:0]     t_q;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	logic [TW-1:0]     team_red;
	logic [CW-1:0]     fdec;
	logic [NW-1:0]     n_alloc;

	logic                 node_we;
	logic [NW-1:0]        node_waddr;
	logic [ITEM_W+TW-1:0] node_wdata;
	logic [ITEM_W+TW-1:0] node_rdata;
	logic [ITEM_W-1:0]    nd_item;
	logic [TW-1:0]        nd_team;

	logic          link_we;
	logic [NW-1:0] link_waddr;
	logic [NW-1:0] link_wdata;
	logic [NW-1:0] link_raddr;
	logic [NW-1:0] link_rdata;

	logic          team_we;
	logic [TW-1:0] team_waddr;
	logic [NW:0]   team_wdata;
	logic [TW-1:0] team_raddr;
	logic [NW:0]   team_rdata;
	logic          tm_act;
	logic [NW-1:0] tm_last;
	logic          tm_grouped;

	logic          free_we;
	logic [NW-1:0] free_raddr;
	logic [NW-1:0] free_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && (state_q == S_IDLE);
	assign is_full  = (fill_q == CW'(NODE_CAPACITY));
	assign is_empty = (fill_q == '0);
	assign done     = done_q;
	assign status   = status_q;
	assign out_item = out_item_q;

	assign nd_item    = node_rdata[ITEM_W-1:0];
	assign nd_team    = node_rdata[ITEM_W +: TW];
	assign tm_act     = team_rdata[NW];
	assign tm_last    = team_rdata[NW-1:0];
	assign tm_grouped = tm_act && !is_empty;
	assign fdec       = fcnt_q - CW'(1);
	assign free_raddr = fdec[NW-1:0];
	assign n_alloc    = (fcnt_q != '0) ? free_rdata : fresh_q[NW-1:0];

	tgf_team_reduce #(
		.TEAM_COUNT(TEAM_COUNT)
	) u_reduce (
		.clk     (clk),
		.load    (accept),
		.team_in (team),
		.team_idx(team_red)
	);

	tgf_ram #(
		.WIDTH(ITEM_W + TW),
		.DEPTH(NODE_CAPACITY)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.raddr(head_q),
		.rdata(node_rdata)
	);

	tgf_ram #(
		.WIDTH(NW),
		.DEPTH(NODE_CAPACITY)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	tgf_ram #(
		.WIDTH(NW + 1),
		.DEPTH(TEAM_COUNT)
	) u_team_ram (
		.clk  (clk),
		.we   (team_we),
		.waddr(team_waddr),
		.wdata(team_wdata),
		.raddr(team_raddr),
		.rdata(team_rdata)
	);

	tgf_ram #(
		.WIDTH(NW),
		.DEPTH(NODE_CAPACITY)
	) u_free_ram (
		.clk  (clk),
		.we   (free_we),
		.waddr(fcnt_q[NW-1:0]),
		.wdata(n_q),
		.raddr(free_raddr),
		.rdata(free_rdata)
	);

	always_comb begin
		node_we    = 1'b0;
		node_waddr = n_alloc;
		node_wdata = {t_q, item_q};
		link_we    = 1'b0;
		link_waddr = tail_q;
		link_wdata = n_alloc;
		link_raddr = (state_q == S_ENQ_A) ? tm_last : head_q;
		team_we    = 1'b0;
		team_waddr = t_q;
		team_wdata = {1'b1, n_alloc};
		team_raddr = (state_q == S_DEQ_A) ? nd_team : team_red;
		free_we    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				team_we    = 1'b1;
				team_waddr = clr_q;
				team_wdata = '0;
			end
			S_ENQ_A: begin
				node_we = 1'b1;
				team_we = 1'b1;
				link_we = !tm_grouped && !is_empty;
			end
			S_ENQ_B: begin
				link_we    = 1'b1;
				link_waddr = n_q;
				link_wdata = link_rdata;
			end
			S_ENQ_C: begin
				link_we    = 1'b1;
				link_waddr = p_q;
				link_wdata = n_q;
			end
			S_DEQ_A: begin
				free_we = 1'b1;
			end
			S_DEQ_B: begin
				team_we    = tm_act && (tm_last == n_q);
				team_waddr = t_q;
				team_wdata = {1'b0, n_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			fresh_q <= '0;
			fcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TW'(1);
					if (clr_q == TW'(TEAM_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_ENQ) begin
							if (is_full) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_MOD;
							end
						end else begin
							if (is_empty) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_DEQ_A;
							end
						end
					end
				end
				S_MOD: begin
					state_q <= S_ENQ_A;
				end
				S_ENQ_A: begin
					fill_q <= fill_q + CW'(1);
					if (fcnt_q != '0) begin
						fcnt_q <= fdec;
					end else begin
						fresh_q <= fresh_q + CW'(1);
					end
					if (tm_grouped) begin
						state_q <= S_ENQ_B;
					end else begin
						if (is_empty) begin
							head_q <= n_alloc;
						end
						tail_q  <= n_alloc;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ENQ_B: begin
					state_q <= S_ENQ_C;
				end
				S_ENQ_C: begin
					if (p_q == tail_q) begin
						tail_q <= n_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEQ_A: begin
					fill_q <= fill_q - CW'(1);
					fcnt_q <= fcnt_q + CW'(1);
					if (fill_q != CW'(1)) begin
						head_q <= link_rdata;
					end
					state_q <= S_DEQ_B;
				end
				S_DEQ_B: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= item_id[ITEM_W-1:0];
				n_q    <= head_q;
				if (accept) begin
					status_q   <= (mode == MODE_ENQ) ? STAT_FULL : STAT_EMPTY;
					out_item_q <= '0;
				end
			end
			S_MOD: begin
				t_q <= team_red;
			end
			S_ENQ_A: begin
				n_q        <= n_alloc;
				p_q        <= tm_last;
				status_q   <= STAT_ENQ;
				out_item_q <= '0;
			end
			S_DEQ_A: begin
				item_q <= nd_item;
				t_q    <= nd_team;
			end
			S_DEQ_B: begin
				status_q   <= STAT_DEQ;
				out_item_q <= ITEM_IN_W'(item_q);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ bench/team_grouped_fifo_test.sv @@
// Self-checking bench for the team grouped FIFO: queued requests, shadow list model, reply check.
module team_grouped_fifo_test;
	import tgf_pkg::*;

	localparam int NODES = NODE_CAPACITY_DEF;
	localparam int TEAMS = TEAM_COUNT_DEF;

	typedef struct {
		logic                 mode;
		logic [ITEM_IN_W-1:0] id;
		logic [TEAM_IN_W-1:0] grp;
		bit                   drain_first;
	} request_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ITEM_IN_W-1:0] item;
	} reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 mode = MODE_ENQ;
	logic [ITEM_IN_W-1:0] item_id = '0;
	logic [TEAM_IN_W-1:0] team = '0;
	logic                 busy;
	logic                 done;
	logic [1:0]           status;
	logic [ITEM_IN_W-1:0] out_item;

	request_t request_q[$];
	reply_t   replies_due[$];
	int       errors = 0;
	int       in_flight = 0;
	int       sent = 0;
	int       gen_fill = 0;
	bit       drain_mark = 1'b0;

	logic [ITEM_W-1:0] node_item [NODES];
	int                node_next [NODES];
	int                node_grp [NODES];
	int                grp_last [TEAMS];
	bit                grp_live [TEAMS];
	int                free_nodes [NODES];
	int                free_cnt;
	int                head_node;
	int                tail_node;
	int                queued;

	team_grouped_fifo i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.item_id  (item_id),
		.team     (team),
		.done     (done),
		.status   (status),
		.out_item (out_item)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	function automatic void predict_reply(input logic op, input logic [ITEM_IN_W-1:0] id,
			input logic [TEAM_IN_W-1:0] grp);
		reply_t rep;
		int     n;
		int     t;
		int     p;
		rep.status = STAT_ENQ;
		rep.item = '0;
		if (op == MODE_ENQ) begin
			if (free_cnt == 0 || queued >= NODES) begin
				rep.status = STAT_FULL;
			end else begin
				t = int'(grp) % TEAMS;
				free_cnt--;
				n = free_nodes[free_cnt] % NODES;
				node_item[n] = id[ITEM_W-1:0];
				node_grp[n] = t;
				if (grp_live[t] && queued != 0) begin
					p = grp_last[t] % NODES;
					node_next[n] = node_next[p];
					node_next[p] = n;
					if (p == tail_node)
						tail_node = n;
				end else begin
					node_next[n] = 0;
					if (queued == 0)
						head_node = n;
					else
						node_next[tail_node % NODES] = n;
					tail_node = n;
				end
				grp_last[t] = n;
				grp_live[t] = 1'b1;
				queued++;
			end
		end else if (queued == 0) begin
			rep.status = STAT_EMPTY;
		end else begin
			n = head_node % NODES;
			rep.status = STAT_DEQ;
			rep.item = ITEM_IN_W'(node_item[n]);
			t = node_grp[n] % TEAMS;
			if (grp_live[t] && grp_last[t] == n)
				grp_live[t] = 1'b0;
			queued--;
			if (queued != 0)
				head_node = node_next[n] % NODES;
			if (free_cnt < NODES) begin
				free_nodes[free_cnt] = n;
				free_cnt++;
			end
		end
		replies_due.push_back(rep);
	endfunction

	task automatic add_enqueue(input logic [ITEM_IN_W-1:0] id, input logic [TEAM_IN_W-1:0] grp);
		request_t r;
		r.mode = MODE_ENQ;
		r.id = id;
		r.grp = grp;
		r.drain_first = drain_mark;
		drain_mark = 1'b0;
		request_q.push_back(r);
		if (gen_fill < NODES)
			gen_fill++;
	endtask

	task automatic add_dequeue();
		request_t r;
		r.mode = MODE_DEQ;
		r.id = ITEM_IN_W'($urandom());
		r.grp = TEAM_IN_W'($urandom());
		r.drain_first = drain_mark;
		drain_mark = 1'b0;
		request_q.push_back(r);
		if (gen_fill > 0)
			gen_fill--;
	endtask

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		bit       idle;
		bit       calm;
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_ENQ;
			item_id <= '0;
			team <= '0;
			in_flight = 0;
			sent = 0;
		end else begin
			if (done)
				in_flight--;
			if (start && !busy) begin
				predict_reply(mode, item_id, team);
				in_flight++;
				sent++;
			end
			if (!(start && busy)) begin
				calm = (sent >= 300 && sent < 550);
				idle = !calm && ($urandom_range(99) < 21);
				if (request_q.size() != 0 && !idle
						&& !(request_q[0].drain_first && in_flight != 0)) begin
					r = request_q.pop_front();
					start <= 1'b1;
					mode <= r.mode;
					item_id <= r.id;
					team <= r.grp;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with no request pending: status %0d item %h",
					status, out_item));
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
				if (out_item !== want.item)
					report_mismatch($sformatf("out_item %h, wanted %h", out_item, want.item));
			end
		end
	end

	initial begin
		logic [TEAM_IN_W-1:0] pool [8];
		int                   rand_count;
		int                   kind;
		int                   nteams;
		int                   len;
		int                   k;
		for (k = 0; k < NODES; k++) begin
			node_item[k] = '0;
			node_next[k] = 0;
			node_grp[k] = 0;
			free_nodes[k] = k;
		end
		for (k = 0; k < TEAMS; k++) begin
			grp_last[k] = 0;
			grp_live[k] = 1'b0;
		end
		free_cnt = NODES;
		head_node = 0;
		tail_node = 0;
		queued = 0;

		add_dequeue();
		add_enqueue('0, '0);
		add_enqueue('1, '1);
		add_enqueue(20'h12345, '0);
		add_enqueue(20'hAAAAA, 10'h2AA);
		add_enqueue(20'h55555, '1);
		add_enqueue(20'h00001, 10'h155);
		add_enqueue(20'h80000, '0);
		add_dequeue();
		add_dequeue();
		add_enqueue(20'h0F0F0, '0);
		add_dequeue();
		add_dequeue();
		add_dequeue();
		add_enqueue(20'hFFFFE, 10'h200);
		add_dequeue();
		add_dequeue();
		add_dequeue();
		add_dequeue();
		add_enqueue(20'h7FFFF, 10'h001);
		add_enqueue(20'h00002, 10'h001);
		add_dequeue();
		add_dequeue();
		add_dequeue();

		rand_count = 0;
		while (rand_count < 60) begin
			kind = $urandom_range(9);
			if (kind < 6) begin
				nteams = $urandom_range(6, 1);
				for (k = 0; k < nteams; k++) begin
					case ($urandom_range(9))
						0: pool[k] = '0;
						1: pool[k] = '1;
						default: pool[k] = TEAM_IN_W'($urandom());
					endcase
				end
				len = $urandom_range(24, 4);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(99) < 30)
						add_dequeue();
					else
						add_enqueue(ITEM_IN_W'($urandom()), pool[$urandom_range(nteams - 1)]);
				end
			end else if (kind < 8) begin
				len = $urandom_range(gen_fill + 2, 1);
				for (k = 0; k < len; k++)
					add_dequeue();
			end else begin
				len = 10;
				for (k = 0; k < len; k++) begin
					if ($urandom_range(1))
						add_dequeue();
					else
						add_enqueue(ITEM_IN_W'($urandom()), TEAM_IN_W'($urandom()));
				end
			end
			rand_count += len;
		end

		// fill to capacity and beyond, then take a few back out
		for (k = 0; k < 8; k++)
			pool[k] = TEAM_IN_W'($urandom());
		drain_mark = 1'b1;
		len = NODES - gen_fill + 3;
		for (k = 0; k < len; k++)
			add_enqueue(ITEM_IN_W'($urandom()), pool[$urandom_range(7)]);
		for (k = 0; k < 24; k++)
			add_dequeue();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || start || replies_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
		if (errors == 0) begin
			$display("team_grouped_fifo_test: PASS");
		end else begin
			$display("team_grouped_fifo_test: FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("team_grouped_fifo_test: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tgf_pkg.sv
rtl/tgf_ram.sv
rtl/tgf_team_reduce.sv
rtl/team_grouped_fifo.sv
bench/team_grouped_fifo_test.sv
